@@ hdl/multilevel_ready_queue_top_assert.svh @@
// Assertion macros shared by the multilevel ready queue RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MULTILEVEL_READY_QUEUE_TOP_ASSERT_SVH
`define MULTILEVEL_READY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRQ_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mrq_pkg.sv @@
// Shared types and constants of the multilevel ready queue.
// No dependencies; used by the interfaces, the RTL modules and the testbench.
package mrq_pkg;

  localparam int ID_W    = 16;
  localparam int STAMP_W = 48;

  // Default sizing, used as the top level's parameter defaults.
  localparam int LEVELS_DEF = 2;
  localparam int SLOTS_DEF  = 16;

  // Result status codes
  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_POPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Request action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Cell load select
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_SHIFT = 2'd2;
  localparam logic [1:0] CELL_WRAP  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Per-row command from the controller; at most one bit set.
  typedef struct packed {
    logic push;
    logic rotate;
    logic drop;
  } row_cmd_t;

endpackage

@@ hdl/mrq_if.sv @@
// Valid/ready channel interfaces of the multilevel ready queue.
// Depends on mrq_pkg for field widths.
interface mrq_req_if import mrq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    proc_id;
  logic               level;
  logic [STAMP_W-1:0] now;

  modport source (output valid, action, proc_id, level, now, input ready);
  modport sink   (input valid, action, proc_id, level, now, output ready);
endinterface

interface mrq_rsp_if import mrq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ID_W-1:0]    out_id;
  logic               out_level;
  logic [STAMP_W-1:0] wait_time;

  modport source (output valid, status, out_id, out_level, wait_time, input ready);
  modport sink   (input valid, status, out_id, out_level, wait_time, output ready);
endinterface

@@ hdl/mrq_cell.sv @@
// One queue cell: holds a single entry and takes a new one from the push
// port, its right neighbor or the row head. Depends on mrq_pkg.
module mrq_cell import mrq_pkg::*; (
  input  logic       clk,
  input  logic [1:0] op,
  input  entry_t     load_entry,
  input  entry_t     nbr_entry,
  input  entry_t     head_entry,
  output entry_t     q
);

  // Payload only, no reset: the row count says which cells hold data.
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:  q <= q;
      CELL_LOAD:  q <= load_entry;
      CELL_SHIFT: q <= nbr_entry;
      CELL_WRAP:  q <= head_entry;
    endcase
  end

endmodule

@@ hdl/mrq_row.sv @@
// One priority level: a row of cells with a fill count. Supports append,
// rotate (head to tail) and drop-head. Depends on mrq_pkg and mrq_cell.
module mrq_row import mrq_pkg::*; #(
  parameter  int SLOTS = SLOTS_DEF,
  localparam int CNTW  = $clog2(SLOTS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  row_cmd_t        cmd,
  input  entry_t          push_entry,
  output entry_t          head,
  output logic [CNTW-1:0] count
);

  `include "multilevel_ready_queue_top_assert.svh"

  entry_t          q [SLOTS];
  logic [CNTW-1:0] last;

  assign last = count - CNTW'(1);
  assign head = q[0];

  // Cells: each looks right for its neighbor, the tail wraps the head around
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [1:0] op;
    entry_t     nbr;

    if (i < SLOTS - 1) begin : g_nbr
      assign nbr = q[i+1];
    end else begin : g_end
      assign nbr = q[0];
    end

    always_comb begin
      priority if (cmd.push && CNTW'(i) == count) begin
        op = CELL_LOAD;
      end else if ((cmd.rotate || cmd.drop) && CNTW'(i) < last) begin
        op = CELL_SHIFT;
      end else if (cmd.rotate && CNTW'(i) == last) begin
        op = CELL_WRAP;
      end else begin
        op = CELL_HOLD;
      end
    end

    mrq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .load_entry (push_entry),
      .nbr_entry  (nbr),
      .head_entry (q[0]),
      .q          (q[i])
    );
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CNTW'(1);
    end else if (cmd.drop) begin
      count <= last;
    end
  end

  `MRQ_ASSERT_IMPL(a_cmd_onehot, clk, rst, 1'b1, $onehot0({cmd.push, cmd.rotate, cmd.drop}), "row got more than one command")
  `MRQ_ASSERT_IMPL(a_no_push_full, clk, rst, cmd.push, count != CNTW'(SLOTS), "push into a full row")
  `MRQ_ASSERT_NEXT(a_drop_count, clk, rst, cmd.drop && count != '0, count == $past(last), "drop did not shrink the row")

endmodule

@@ hdl/multilevel_ready_queue_top.sv @@
// Multilevel ready queue, top level. Depends on mrq_pkg, mrq_if and mrq_row.
//
// Keeps LEVELS queues of up to SLOTS (process id, time stamp) entries, each
// queue a row of cells. One request is handled at a time. A push, a rejected
// push or a pop with every level empty goes straight to the done state, whose
// result is then loaded into the output register. A pop serving a level that
// holds n entries runs in two passes: the row rotates once through all n cells
// to find the oldest stamp (earliest position on ties), then rotates once more,
// dropping that entry as it passes the head, so the rest keep their order. The
// next request is taken while a result beat still waits on the response channel.
module multilevel_ready_queue_top import mrq_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input logic    clk,
  input logic    rst,
  mrq_req_if.sink   req,
  mrq_rsp_if.source rsp
);

  `include "multilevel_ready_queue_top_assert.svh"

  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW   = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DROP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [LW-1:0]      sel;
  logic [CW-1:0]      step;
  logic [CW-1:0]      last_idx;
  logic [CW-1:0]      best;
  logic [STAMP_W-1:0] best_stamp;
  logic [STAMP_W-1:0] now_r;

  logic [1:0]         res_status;
  logic [ID_W-1:0]    res_id;
  logic               res_level;
  logic [STAMP_W-1:0] res_wait;

  logic               out_valid;
  logic [1:0]         out_status;
  logic [ID_W-1:0]    out_id_r;
  logic               out_level_r;
  logic [STAMP_W-1:0] out_wait;

  row_cmd_t        row_cmd [LEVELS];
  entry_t          head    [LEVELS];
  logic [CNTW-1:0] cnt     [LEVELS];

  logic            accept;
  logic            lvl_ok;
  logic            lvl_full;
  logic            push_go;
  logic            any_busy;
  logic [LW-1:0]   first_lvl;
  entry_t          hd;
  logic [CNTW-1:0] sel_cnt;
  entry_t          push_entry;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign push_entry = '{id: req.proc_id, stamp: req.now};
  assign hd         = head[sel];
  assign sel_cnt    = cnt[sel];

  // Push target check and lowest non-empty level
  always_comb begin
    lvl_ok    = (int'(req.level) < LEVELS);
    lvl_full  = 1'b0;
    any_busy  = 1'b0;
    first_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (l == int'(req.level)) begin
        lvl_full = (cnt[l] == CNTW'(SLOTS));
      end
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt[l] != '0) begin
        any_busy  = 1'b1;
        first_lvl = LW'(l);
      end
    end
  end

  assign push_go = accept && (req.action == ACT_PUSH) && lvl_ok && !lvl_full;

  // Row commands
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      row_cmd[l].push   = push_go && (l == int'(req.level));
      row_cmd[l].rotate = (sel == LW'(l)) &&
                          ((state == S_SCAN) || (state == S_DROP && step != best));
      row_cmd[l].drop   = (sel == LW'(l)) && (state == S_DROP) && (step == best);
    end
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_row
    mrq_row #(.SLOTS(SLOTS)) u_row (
      .clk        (clk),
      .rst        (rst),
      .cmd        (row_cmd[l]),
      .push_entry (push_entry),
      .head       (head[l]),
      .count      (cnt[l])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_id    <= '0;
            res_level <= 1'b0;
            res_wait  <= '0;
            if (req.action == ACT_PUSH) begin
              res_status <= push_go ? ST_PUSHED : ST_FULL;
              state      <= S_DONE;
            end else if (!any_busy) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              sel      <= first_lvl;
              now_r    <= req.now;
              step     <= '0;
              last_idx <= CW'(cnt[first_lvl] - CNTW'(1));
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // oldest stamp so far, earliest position wins ties
          if (step == '0 || hd.stamp < best_stamp) begin
            best       <= step;
            best_stamp <= hd.stamp;
          end
          if (step == last_idx) begin
            step  <= '0;
            state <= S_DROP;
          end else begin
            step <= step + CW'(1);
          end
        end
        S_DROP: begin
          if (step == best) begin
            res_id <= hd.id;
          end
          if (step == last_idx) begin
            res_status <= ST_POPPED;
            res_level  <= sel[0];
            res_wait   <= now_r - best_stamp;
            state      <= S_DONE;
          end else begin
            step <= step + CW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_status  <= res_status;
      out_id_r    <= res_id;
      out_level_r <= res_level;
      out_wait    <= res_wait;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.out_id    = out_id_r;
  assign rsp.out_level = out_level_r;
  assign rsp.wait_time = out_wait;

  `MRQ_ASSERT_IMPL(a_scan_nonempty, clk, rst, state == S_SCAN, sel_cnt != '0, "scanning an empty level")
  `MRQ_ASSERT_IMPL(a_pop_shrinks, clk, rst, state == S_DONE && $past(state) == S_DROP, sel_cnt == CNTW'(last_idx), "pop left wrong count")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for multilevel_ready_queue_top: push/pop requests are
// predicted by a cycle-free scheduler model and checked beat by beat.
// Depends on mrq_pkg and mrq_if (RTL) and on the top level of the block.
module tb import mrq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS         = LEVELS_DEF;
  localparam int SLOTS          = SLOTS_DEF;
  localparam int N_RANDOM       = 2000;
  localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic               action;
    logic [ID_W-1:0]    pid;
    logic               level;
    logic [STAMP_W-1:0] now;
  } sched_req_t;

  typedef struct {
    logic [1:0]         status;
    logic [ID_W-1:0]    id;
    logic               lvl;
    logic [STAMP_W-1:0] wait_us;
  } sched_result_t;

  logic clk;
  logic rst;

  mrq_req_if req_ch ();
  mrq_rsp_if rsp_ch ();

  multilevel_ready_queue_top #(
    .LEVELS(LEVELS),
    .SLOTS (SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Model state: one row of entries per level, kept in queue order
  entry_t      ready_rows [LEVELS][SLOTS];
  int unsigned row_fill   [LEVELS];

  sched_req_t    request_q [$];
  sched_result_t pending_results [$];

  int unsigned n_accepted;
  int unsigned n_requests;
  int unsigned n_mismatch;
  int unsigned idle_cycles;
  int unsigned n_status [4];

  logic        req_taken;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pat;
  logic [5:0]  pat_age;
  logic [15:0] next_pat;

  always #2 clk = ~clk;

  // Scheduler model: applies one request and returns its result
  function automatic sched_result_t schedule_request(sched_req_t rq);
    sched_result_t r;
    int            best;
    bit            served;
    r.status  = ST_EMPTY;
    r.id      = '0;
    r.lvl     = 1'b0;
    r.wait_us = '0;
    served    = 1'b0;
    if (rq.action == ACT_PUSH) begin
      if (int'(rq.level) >= LEVELS || row_fill[rq.level] >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        ready_rows[rq.level][row_fill[rq.level]].id    = rq.pid;
        ready_rows[rq.level][row_fill[rq.level]].stamp = rq.now;
        row_fill[rq.level]++;
        r.status = ST_PUSHED;
      end
    end else begin
      for (int lv = 0; lv < LEVELS; lv++) begin
        if (!served && row_fill[lv] != 0) begin
          // oldest stamp wins, earliest position on ties
          best = 0;
          for (int i = 1; i < row_fill[lv]; i++)
            if (ready_rows[lv][best].stamp > ready_rows[lv][i].stamp) best = i;
          r.status  = ST_POPPED;
          r.id      = ready_rows[lv][best].id;
          r.lvl     = lv[0];
          r.wait_us = rq.now - ready_rows[lv][best].stamp;
          for (int i = best + 1; i < row_fill[lv]; i++)
            ready_rows[lv][i-1] = ready_rows[lv][i];
          row_fill[lv]--;
          served = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic add_request(input logic act, input logic [ID_W-1:0] pid,
                             input logic lvl, input logic [STAMP_W-1:0] now);
    sched_req_t rq;
    rq.action = act;
    rq.pid    = pid;
    rq.level  = lvl;
    rq.now    = now;
    request_q.push_back(rq);
  endtask

  // Request driver: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (request_q.size() != 0) begin
        req_ch.valid   <= 1'b1;
        req_ch.action  <= request_q[0].action;
        req_ch.proc_id <= request_q[0].pid;
        req_ch.level   <= request_q[0].level;
        req_ch.now     <= request_q[0].now;
        void'(request_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response stall pattern, rotated each cycle and reloaded when the 6-bit age counter wraps
  always @(negedge clk) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0:       next_pat = 16'hFFFF;
        1:       next_pat = 16'($urandom) | 16'h0001;
        2:       next_pat = 16'($urandom | $urandom) | 16'h0001;
        default: next_pat = 16'($urandom & $urandom) | 16'h0001;
      endcase
    end else begin
      next_pat = {stall_pat[0], stall_pat[15:1]};
    end
    stall_pat    <= next_pat;
    rsp_ch.ready <= next_pat[0];
    pat_age      <= pat_age + 6'd1;
  end

  // Monitor: check result beats, predict on request beats, watchdog
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t exp_r;
    req_taken <= req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status  = rsp_ch.status;
        got.id      = rsp_ch.out_id;
        got.lvl     = rsp_ch.out_level;
        got.wait_us = rsp_ch.wait_time;
        n_status[got.status]++;
        if (pending_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("[%0t] unexpected result beat: status %0d id %h lvl %0d wait %h",
                     $realtime, got.status, got.id, got.lvl, got.wait_us);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.status !== exp_r.status || got.id !== exp_r.id ||
              got.lvl !== exp_r.lvl || got.wait_us !== exp_r.wait_us) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
              $display("[%0t] result mismatch: exp status %0d id %h lvl %0d wait %h,",
                       $realtime, exp_r.status, exp_r.id, exp_r.lvl, exp_r.wait_us,
                       " got status %0d id %h lvl %0d wait %h",
                       got.status, got.id, got.lvl, got.wait_us);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(schedule_request('{req_ch.action, req_ch.proc_id,
                                                     req_ch.level, req_ch.now}));
        n_accepted++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $realtime, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [STAMP_W-1:0] stamp_clk;
    int unsigned        phase_left;
    int unsigned        push_pct;
    int unsigned        l1_pct;
    logic               act;

    clk            = 1'b0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_PUSH;
    req_ch.proc_id = '0;
    req_ch.level   = 1'b0;
    req_ch.now     = '0;
    rsp_ch.ready   = 1'b0;
    req_taken      = 1'b0;
    burst_left     = 1;
    gap_left       = 0;
    stall_pat      = 16'hFFFF;
    pat_age        = '0;
    n_accepted     = 0;
    n_mismatch     = 0;
    idle_cycles    = 0;
    n_status       = '{default: 0};
    foreach (row_fill[i]) row_fill[i] = 0;

    // Directed: pop with nothing queued, stray fields on the pop
    add_request(ACT_POP, 16'hFFFF, 1'b1, 48'd7);
    // fill level 1 with ties and extreme stamps and ids, then overflow it
    add_request(ACT_PUSH, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    add_request(ACT_PUSH, 16'h0000, 1'b1, 48'd5);
    add_request(ACT_PUSH, 16'h1234, 1'b1, 48'd5);
    for (int i = 3; i < SLOTS; i++)
      add_request(ACT_PUSH, 16'(16'h0100 + i), 1'b1, 48'(10 + i));
    add_request(ACT_PUSH, 16'hBEEF, 1'b1, 48'd50);
    // level 0 is served first even though level 1 is older
    add_request(ACT_PUSH, 16'h8000, 1'b0, 48'd100);
    add_request(ACT_POP, 16'h0000, 1'b0, 48'd100);
    // clock behind the stamp: wait wraps; then the tie on stamp 5 resolves in order
    add_request(ACT_POP, 16'hAAAA, 1'b0, 48'd3);
    add_request(ACT_POP, 16'h5555, 1'b1, 48'hFFFF_FFFF_FFFF);

    // Random phases with a shifting push/pop mix and level bias
    stamp_clk  = 48'd1000;
    phase_left = 0;
    push_pct   = 50;
    l1_pct     = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 120);
        case ($urandom_range(0, 3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 65;
          default: push_pct = 90;
        endcase
        l1_pct = 25 * $urandom_range(0, 4);
      end
      phase_left--;
      if ($urandom_range(0, 31) == 0)
        stamp_clk = 48'({$urandom, $urandom});
      else
        stamp_clk = stamp_clk + 48'($urandom_range(0, 3));
      act = ($urandom_range(1, 100) <= push_pct) ? ACT_PUSH : ACT_POP;
      add_request(act, 16'($urandom), $urandom_range(1, 100) <= l1_pct, stamp_clk);
    end
    n_requests = request_q.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (n_accepted < n_requests) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      n_mismatch++;
      $display("%0d results never arrived", pending_results.size());
    end
    $display("Ran %0d requests: %0d pushed, %0d rejected as full, %0d popped, %0d on empty.",
             n_accepted, n_status[ST_PUSHED], n_status[ST_FULL], n_status[ST_POPPED],
             n_status[ST_EMPTY]);
    $display("Result beats checked against the scheduler model, %0d mismatches.", n_mismatch);
    if (n_mismatch == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
